// ===== rtl/fmal_pkg.sv =====
package fmal_pkg;

   localparam int LENGTH_BITS_DEF = 24;
   localparam int SAMPLE_W        = 16;
   localparam int LEVEL_W         = 16;
   localparam int FRAME_COUNT_W   = 12;
   localparam int CSR_INDEX_W     = 2;

   localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 12'd79;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] REG_REGION_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_COUNT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_POSITION = 2'd2;

   typedef enum logic [1:0] {
      ST_START,
      ST_SETUP,
      ST_IDLE,
      ST_FRAME
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic restart;      // reload run state, start frame size divide
      logic set_spf;      // frame size divide finished
      logic take_item;    // accumulate accepted sample
      logic close_frame;  // sample ends a frame, start level divide
      logic emit_zero;    // zero frame size result now
      logic load_level;   // move level divide result to output
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic active;       // not finished, frame size nonzero
      logic zero_emit;    // not finished, frame size zero
      logic frame_end;    // next sample completes the frame
      logic out_free;     // output register can load this cycle
   } status_type;

endpackage

// ===== rtl/fmal_ifs.sv =====
interface fmal_req_if;
   import fmal_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] audio_sample;
   modport source (output valid, output audio_sample, input ready);
   modport sink   (input valid, input audio_sample, output ready);
endinterface

interface fmal_rsp_if #(parameter int POS_W = fmal_pkg::LENGTH_BITS_DEF + 1);
   import fmal_pkg::*;
   logic               valid;
   logic               ready;
   logic [POS_W-1:0]   frame_end_position;
   logic [LEVEL_W-1:0] frame_level;
   logic               final_frame;
   modport source (output valid, output frame_end_position, output frame_level,
                   output final_frame, input ready);
   modport sink   (input valid, input frame_end_position, input frame_level,
                   input final_frame, output ready);
endinterface

interface fmal_csr_if #(parameter int DATA_W = fmal_pkg::LENGTH_BITS_DEF);
   import fmal_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fmal_div.sv =====
module fmal_div #(
   parameter int DEND_W = 40,
   parameter int DIVR_W = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DEND_W-1:0] dividend,
   input  logic [DIVR_W-1:0] divisor,
   output logic [DEND_W-1:0] quotient,
   output logic              done
);
   localparam int CNT_W = $clog2(DEND_W + 1);

   logic [DEND_W-1:0] quo_ff, quo_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVR_W:0]   trial;
   logic [DIVR_W:0]   diff;

   // restoring divide, one quotient bit per cycle, MSB first
   always_comb begin
      trial   = {rem_ff, quo_ff[DEND_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[DIVR_W]) begin
            rem_in = diff[DIVR_W-1:0];
            quo_in = {quo_ff[DEND_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVR_W-1:0];
            quo_in = {quo_ff[DEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/fmal_datapath.sv =====
module fmal_datapath #(
   parameter int LENGTH_BITS = fmal_pkg::LENGTH_BITS_DEF,
   parameter int CSR_DATA_W  = fmal_pkg::LENGTH_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fmal_pkg::cmd_type                    cmd,
   output fmal_pkg::status_type                 sts,
   input  logic                                 csr_write,
   input  logic [fmal_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]                csr_data,
   input  logic signed [fmal_pkg::SAMPLE_W-1:0] audio_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [LENGTH_BITS:0]                 frame_end_position,
   output logic [fmal_pkg::LEVEL_W-1:0]         frame_level,
   output logic                                 final_frame
);
   import fmal_pkg::*;

   localparam int SUM_W  = LENGTH_BITS + SAMPLE_W;
   localparam int POS_W  = LENGTH_BITS + 1;
   localparam int DIVR_W = (LENGTH_BITS > FRAME_COUNT_W) ? LENGTH_BITS : FRAME_COUNT_W;

   logic [LENGTH_BITS-1:0]   region_ff, region_in;
   logic [FRAME_COUNT_W-1:0] fcount_ff, fcount_in;
   logic [LENGTH_BITS-1:0]   start_ff, start_in;

   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [LENGTH_BITS-1:0]   cnt_ff, cnt_in;
   logic [FRAME_COUNT_W-1:0] frames_ff, frames_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [LENGTH_BITS-1:0]   spf_ff, spf_in;
   logic                     finished_ff, finished_in;

   logic [POS_W-1:0]         pend_pos_ff, pend_pos_in;
   logic                     pend_final_ff, pend_final_in;

   logic                     out_valid_ff, out_valid_in;
   logic [POS_W-1:0]         out_pos_ff, out_pos_in;
   logic [LEVEL_W-1:0]       out_level_ff, out_level_in;
   logic                     out_final_ff, out_final_in;

   logic [SAMPLE_W-1:0]      raw;
   logic [SAMPLE_W-1:0]      mag;
   logic [SUM_W-1:0]         sum_next;
   logic [FRAME_COUNT_W-1:0] frames_next;
   logic                     final_now;

   logic                     div_start;
   logic [SUM_W-1:0]         div_dend;
   logic [DIVR_W-1:0]        div_dvs;
   logic [SUM_W-1:0]         div_quo;
   logic                     div_done;

   assign raw         = audio_sample;
   assign mag         = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
   assign sum_next    = sum_ff + SUM_W'(mag);
   assign frames_next = frames_ff + FRAME_COUNT_W'(1);
   assign final_now   = (frames_next == fcount_ff);

   // shared divider: frame size at setup, level at frame end
   assign div_start = cmd.restart | cmd.close_frame;
   assign div_dend  = cmd.restart ? SUM_W'(region_ff) : sum_next;
   assign div_dvs   = cmd.restart ? DIVR_W'(fcount_ff) : DIVR_W'(spf_ff);

   fmal_div #(
      .DEND_W (SUM_W),
      .DIVR_W (DIVR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dend),
      .divisor  (div_dvs),
      .quotient (div_quo),
      .done     (div_done)
   );

   always_comb begin
      region_in = region_ff;
      fcount_in = fcount_ff;
      start_in  = start_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_REGION_LENGTH:  region_in = csr_data[LENGTH_BITS-1:0];
            REG_FRAME_COUNT:    fcount_in = csr_data[FRAME_COUNT_W-1:0];
            REG_START_POSITION: start_in  = csr_data[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sum_in        = sum_ff;
      cnt_in        = cnt_ff;
      frames_in     = frames_ff;
      pos_in        = pos_ff;
      spf_in        = spf_ff;
      finished_in   = finished_ff;
      pend_pos_in   = pend_pos_ff;
      pend_final_in = pend_final_ff;
      out_valid_in  = out_valid_ff;
      out_pos_in    = out_pos_ff;
      out_level_in  = out_level_ff;
      out_final_in  = out_final_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.restart) begin
         sum_in      = '0;
         cnt_in      = '0;
         frames_in   = '0;
         pos_in      = POS_W'(start_ff);
         finished_in = (fcount_ff == '0);
      end

      if (cmd.set_spf) begin
         spf_in = (fcount_ff == '0) ? '0 : div_quo[LENGTH_BITS-1:0];
      end

      if (cmd.take_item) begin
         pos_in = pos_ff + POS_W'(1);
         if (cmd.close_frame) begin
            sum_in        = '0;
            cnt_in        = '0;
            frames_in     = frames_next;
            finished_in   = finished_ff | final_now;
            pend_pos_in   = pos_ff + POS_W'(1);
            pend_final_in = final_now;
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_ff + LENGTH_BITS'(1);
         end
      end

      if (cmd.emit_zero) begin
         frames_in    = frames_next;
         finished_in  = finished_ff | final_now;
         out_valid_in = 1'b1;
         out_pos_in   = pos_ff;
         out_level_in = '0;
         out_final_in = final_now;
      end

      if (cmd.load_level) begin
         out_valid_in = 1'b1;
         out_pos_in   = pend_pos_ff;
         out_level_in = div_quo[LEVEL_W-1:0];
         out_final_in = pend_final_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= '0;
         fcount_ff    <= FRAME_COUNT_RESET;
         start_ff     <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         frames_ff    <= '0;
         pos_ff       <= '0;
         spf_ff       <= '0;
         finished_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         region_ff    <= region_in;
         fcount_ff    <= fcount_in;
         start_ff     <= start_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         frames_ff    <= frames_in;
         pos_ff       <= pos_in;
         spf_ff       <= spf_in;
         finished_ff  <= finished_in;
         out_valid_ff <= out_valid_in;
      end
      pend_pos_ff   <= pend_pos_in;
      pend_final_ff <= pend_final_in;
      out_pos_ff    <= out_pos_in;
      out_level_ff  <= out_level_in;
      out_final_ff  <= out_final_in;
   end

   always_comb begin
      sts.div_done  = div_done;
      sts.active    = !finished_ff && (spf_ff != '0);
      sts.zero_emit = !finished_ff && (spf_ff == '0);
      sts.frame_end = ({1'b0, cnt_ff} + (LENGTH_BITS+1)'(1)) >= {1'b0, spf_ff};
      sts.out_free  = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid          = out_valid_ff;
   assign frame_end_position = out_pos_ff;
   assign frame_level        = out_level_ff;
   assign final_frame        = out_final_ff;

endmodule

// ===== rtl/fmal_ctrl.sv =====
module fmal_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 csr_write,
   input  fmal_pkg::status_type sts,
   output logic                 req_ready,
   output fmal_pkg::cmd_type    cmd
);
   import fmal_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   always_comb begin
      state_in = state_ff;
      if (csr_write) begin
         state_in = ST_START;
      end else begin
         unique case (state_ff)
            ST_START: state_in = ST_SETUP;
            ST_SETUP: if (sts.div_done) state_in = ST_IDLE;
            ST_IDLE:  if (accept && sts.active && sts.frame_end) state_in = ST_FRAME;
            ST_FRAME: if (sts.div_done && sts.out_free) state_in = ST_IDLE;
            default:  state_in = ST_START;
         endcase
      end
   end

   always_comb begin
      req_ready       = (state_ff == ST_IDLE) && (!sts.zero_emit || sts.out_free);
      accept          = req_valid && req_ready;
      cmd.restart     = (state_ff == ST_START);
      cmd.set_spf     = (state_ff == ST_SETUP) && sts.div_done;
      cmd.take_item   = accept && sts.active;
      cmd.close_frame = accept && sts.active && sts.frame_end;
      cmd.emit_zero   = accept && sts.zero_emit;
      cmd.load_level  = (state_ff == ST_FRAME) && sts.div_done && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/frame_mean_abs_level.sv =====
// Frame mean absolute level.
// req_bus carries one signed 16-bit sample per transfer; rsp_bus carries one
// result per finished frame: position after the frame, truncated mean of
// |sample| over the frame, and a flag on the last configured frame.
// csr_bus writes region_length (0), frame_count (1), start_position (2);
// it is always ready and any write to a known index restarts the run.
// Index 3 is accepted and dropped.
// After reset or a restart the frame size (region_length / frame_count) is
// computed on the shared radix-2 divider with req_bus.ready low.
// Throughput: one sample per cycle inside a frame. The sample that closes
// a frame starts a level divide on the same divider; the result loads the
// output register once the divide is done and that register is free, and the
// next sample is taken the cycle after the result loads the output register.
// With a zero frame size each sample yields a level 0 result in the next cycle.
// The output register holds a result until rsp_bus transfers it; a stalled
// receiver stops input only when a new result must load behind it.
// After the last frame samples are taken and dropped.
module frame_mean_abs_level #(
   parameter int LENGTH_BITS = fmal_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   fmal_req_if.sink    req_bus,
   fmal_rsp_if.source  rsp_bus,
   fmal_csr_if.sink    csr_bus
);
   import fmal_pkg::*;

   localparam int CSR_DATA_W = (LENGTH_BITS > FRAME_COUNT_W) ? LENGTH_BITS : FRAME_COUNT_W;

   cmd_type    cmd;
   status_type sts;
   logic       csr_write;
   logic       csr_restart;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;
   // only a transfer to one of the three registers restarts the run
   assign csr_restart   = csr_write && (csr_bus.index == REG_REGION_LENGTH
                                        || csr_bus.index == REG_FRAME_COUNT
                                        || csr_bus.index == REG_START_POSITION);

   // sequencer: setup divide, sample intake, level divide
   fmal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .csr_write (csr_restart),
      .sts       (sts),
      .req_ready (req_bus.ready),
      .cmd       (cmd)
   );

   // config registers, accumulator, counters, divider, output register
   fmal_datapath #(
      .LENGTH_BITS (LENGTH_BITS),
      .CSR_DATA_W  (CSR_DATA_W)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_write          (csr_write),
      .csr_index          (csr_bus.index),
      .csr_data           (csr_bus.data[CSR_DATA_W-1:0]),
      .audio_sample       (req_bus.audio_sample),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .frame_end_position (rsp_bus.frame_end_position),
      .frame_level        (rsp_bus.frame_level),
      .final_frame        (rsp_bus.final_frame)
   );

   // a register write always stops intake until the frame size is recomputed
   assert property (@(posedge clock) disable iff (reset)
      csr_restart |=> !req_bus.ready)
      else $error("input ready right after a config transfer");

   // a frame-closing sample holds off the next one while the divide runs
   assert property (@(posedge clock) disable iff (reset)
      cmd.close_frame |=> !req_bus.ready)
      else $error("input ready during level divide");

   // a zero frame size sample shows its result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_zero |=> rsp_bus.valid)
      else $error("zero frame size result missing");

   // a level result only loads when the output register can take it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready && !cmd.load_level && !cmd.emit_zero)
         |=> $stable(rsp_bus.frame_level))
      else $error("pending result overwritten");

endmodule

// ===== tb/sv/tb_frame_mean_abs_level.sv =====
module tb_frame_mean_abs_level;
   timeunit 1ns;
   timeprecision 1ps;
   import fmal_pkg::*;

   localparam int LB    = LENGTH_BITS_DEF;
   localparam int POS_W = LB + 1;

   // index 3 is not a register: the block takes the transfer and drops it
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   // quiet time before a register write: longer than the setup divide
   // and the level divide put together
   localparam int SETTLE_CYCLES  = 2 * (LB + 18);
   // watchdog: cycles with no transfer on any channel
   localparam int STALL_LIMIT    = 4000;
   // long receiver hold-off for the output back-pressure test
   localparam int PRESSURE_HOLD  = 400;
   // stop points of the random runs
   localparam int RANDOM_ITEMS   = 800;
   localparam int RANDOM_FRAMES  = 48;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef struct packed {
      logic [POS_W-1:0]   pos;
      logic [LEVEL_W-1:0] level;
      logic               last;
   } frame_result_type;

   // receiver ready patterns
   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_type;

   logic clock;
   logic reset;

   fmal_req_if                    req_ch ();
   fmal_rsp_if #(.POS_W(POS_W))   rsp_ch ();
   fmal_csr_if #(.DATA_W(LB))     csr_ch ();

   frame_mean_abs_level #(.LENGTH_BITS(LB)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Level predictor: register copies plus run state
   // ---------------------------------------------------------------------
   logic [LB-1:0]            cfg_region_len;
   logic [FRAME_COUNT_W-1:0] cfg_frames;
   logic [LB-1:0]            cfg_start;

   logic [39:0]              abs_sum;
   logic [LB-1:0]            frame_fill;   // samples summed in the open frame
   logic [FRAME_COUNT_W-1:0] frames_out;
   logic [POS_W-1:0]         position;
   logic [LB-1:0]            frame_len;
   bit                       run_done;

   frame_result_type pending_frames[$];  // levels owed by the block, oldest first

   int live_items;    // accepted samples that the block did not drop
   int frames_seen;   // results transferred
   int mismatches;

   // every register write starts the run over from the register values
   function automatic void rearm_frames();
      abs_sum    = '0;
      frame_fill = '0;
      frames_out = '0;
      position   = POS_W'(cfg_start);
      if (cfg_frames == '0) begin
         frame_len = '0;
         run_done  = 1'b1;      // no frames at all: everything is dropped
      end else begin
         frame_len = LB'(cfg_region_len / cfg_frames);
         run_done  = 1'b0;
      end
   endfunction

   function automatic void reset_predictor();
      cfg_region_len = '0;
      cfg_frames     = FRAME_COUNT_RESET;
      cfg_start      = '0;
      rearm_frames();
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [LB-1:0] value);
      case (idx)
         REG_REGION_LENGTH:  cfg_region_len = value;
         REG_FRAME_COUNT:    cfg_frames     = value[FRAME_COUNT_W-1:0];
         REG_START_POSITION: cfg_start      = value;
         default:            return;     // dropped write, run goes on
      endcase
      rearm_frames();
   endfunction

   function automatic void close_frame(input logic [LEVEL_W-1:0] level);
      frame_result_type r;
      frames_out = frames_out + 1'b1;
      r.pos   = position;
      r.level = level;
      r.last  = (frames_out == cfg_frames);
      if (r.last)
         run_done = 1'b1;
      pending_frames.push_back(r);
   endfunction

   function automatic void take_sample(input logic signed [SAMPLE_W-1:0] s);
      logic [SAMPLE_W:0] ext;
      logic [SAMPLE_W:0] mag;
      logic [39:0]       quotient;
      if (run_done)
         return;
      live_items++;
      // zero frame size: nothing summed, position held, level 0 per sample
      if (frame_len == '0) begin
         close_frame('0);
         return;
      end
      // one extra bit so the most negative sample has a magnitude
      ext = {s[SAMPLE_W-1], s};
      mag = s[SAMPLE_W-1] ? -ext : ext;
      abs_sum    = abs_sum + mag;
      frame_fill = frame_fill + 1'b1;
      position   = position + 1'b1;
      if (frame_fill < frame_len)
         return;
      quotient   = abs_sum / frame_len;
      abs_sum    = '0;
      frame_fill = '0;
      close_frame(quotient[LEVEL_W-1:0]);
   endfunction

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   function automatic void report_mismatch(input string what, input frame_result_type want,
                                           input frame_result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("result %0d %s: expected pos=%0d level=%0d last=%0b, got pos=%0d level=%0d last=%0b",
                  frames_seen, what, want.pos, want.level, want.last,
                  got.pos, got.level, got.last);
   endfunction

   always @(posedge clock) begin
      frame_result_type want;
      frame_result_type got;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         frames_seen++;
         got.pos   = rsp_ch.frame_end_position;
         got.level = rsp_ch.frame_level;
         got.last  = rsp_ch.final_frame;
         if (pending_frames.size() == 0) begin
            report_mismatch("with none owed", '0, got);
         end else begin
            want = pending_frames.pop_front();
            if (got.pos !== want.pos || got.level !== want.level || got.last !== want.last)
               report_mismatch("differs", want, got);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: ready follows a mode picked at random every so often;
   // a hold request from a test holds ready low until hold_left runs out
   // ---------------------------------------------------------------------
   rx_mode_type rx_mode;
   int          rx_left;
   int          hold_asks;       // bumped by tests
   int          holds_served;    // owned by the receiver
   int          hold_left;

   always @(posedge clock) begin
      if (hold_asks != holds_served) begin
         holds_served = hold_asks;
         hold_left    = PRESSURE_HOLD;
      end
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ch.ready <= (rx_left % 3 != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: ends the run when no channel moves for too long
   // ---------------------------------------------------------------------
   int quiet_cycles;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("frame_mean_abs_level: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sample sender: bursts of random length with random gaps; valid is
   // left high after a transfer so back-to-back samples never drop it
   // ---------------------------------------------------------------------
   int burst_left;

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap_len;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap_len > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.audio_sample <= s;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      take_sample(s);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(0, 7))
         0:       return SAMPLE_MIN;
         1:       return SAMPLE_MAX;
         2:       return SAMPLE_W'(int'($urandom_range(0, 32)) - 16);  // near zero
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // drop valid, wait for every owed level, then let the divider go quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // more = 1 keeps csr valid high for a write in the next cycle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [LB-1:0] value,
                            input bit more);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      apply_reg(idx, value);
      if (!more)
         csr_ch.valid <= 1'b0;
   endtask

   task automatic set_run(input logic [LB-1:0] region, input logic [FRAME_COUNT_W-1:0] frames,
                          input logic [LB-1:0] start);
      write_reg(REG_REGION_LENGTH, region, 1'b1);
      write_reg(REG_FRAME_COUNT, LB'(frames), 1'b1);
      write_reg(REG_START_POSITION, start, 1'b0);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset values give a zero frame size: level 0 at position 0 per sample
   task automatic test_reset_state();
      repeat (3) send_sample(rand_sample());
      settle();
   endtask

   // largest magnitudes, position past 2^24, samples after the last frame
   task automatic test_sample_extremes();
      set_run(24'd4, 12'd2, '1);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);               // level 32768
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_W'(-1));            // last frame
      send_sample(SAMPLE_MIN);               // dropped
      send_sample('0);                       // dropped
      settle();
   endtask

   // zero frames: run is over before it starts
   task automatic test_zero_frame_count();
      set_run(24'd100, '0, 24'd5);
      repeat (3) send_sample(rand_sample());
      settle();
   endtask

   // region shorter than the frame count: zero frame size through the last frame
   task automatic test_zero_frame_size();
      set_run(24'd2, 12'd3, 24'd77);
      repeat (4) send_sample(rand_sample());
      settle();
   endtask

   // a write to the unused index must not restart the run
   task automatic test_spare_register();
      set_run(24'd6, 12'd2, '0);
      repeat (2) send_sample(rand_sample());
      settle();
      write_reg(REG_SPARE, '1, 1'b0);
      repeat (4) send_sample(rand_sample());
      settle();
   endtask

   // one register written alone still restarts the run mid-frame
   task automatic test_single_write_restart();
      set_run(24'd9, 12'd3, 24'd40);
      repeat (2) send_sample(rand_sample());
      settle();
      write_reg(REG_START_POSITION, 24'd1000, 1'b0);
      repeat (3) send_sample(rand_sample());
      settle();
   endtask

   // all-ones registers, then the largest frame count with zero frame size
   task automatic test_largest_settings();
      set_run('1, '1, '1);
      repeat (3) send_sample(rand_sample());
      settle();
      write_reg(REG_REGION_LENGTH, '0, 1'b0);
      repeat (3) send_sample(rand_sample());
      settle();
   endtask

   // receiver holds off while samples keep coming: the output register
   // fills and the block has to stall its input
   task automatic test_output_backpressure();
      set_run('0, 12'd50, 24'd9);
      hold_asks++;
      repeat (30) send_sample(rand_sample());
      settle();
   endtask

   // whole runs with random sizes, a few cut short, a few with long frames
   task automatic test_random_runs();
      int               base_items;
      int               base_frames;
      int               size;
      int               frames;
      int               full;
      int               n;
      logic [LB-1:0]    region;
      logic [LB-1:0]    start;
      base_items  = live_items;
      base_frames = frames_seen;
      while (live_items - base_items < RANDOM_ITEMS || frames_seen - base_frames < RANDOM_FRAMES) begin
         case ($urandom_range(0, 9))
            0: begin                      // zero frame size
               frames = $urandom_range(1, 20);
               size   = 0;
            end
            1: begin                      // long frames
               frames = $urandom_range(1, 3);
               size   = $urandom_range(100, 300);
            end
            default: begin
               frames = $urandom_range(1, 12);
               size   = $urandom_range(1, 12);
            end
         endcase
         // remainder below the frame count keeps the frame size exact
         region = LB'(size * frames + $urandom_range(0, frames - 1));
         case ($urandom_range(0, 7))
            0:       start = '1;
            1:       start = '0;
            default: start = LB'($urandom);
         endcase
         full = (size == 0) ? frames : size * frames;
         if ($urandom_range(0, 4) == 0)
            n = $urandom_range(1, full);            // broken off mid-run
         else
            n = full + $urandom_range(0, 3);        // a few dropped at the end
         set_run(region, FRAME_COUNT_W'(frames), start);
         repeat (n) send_sample(rand_sample());
         settle();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.audio_sample <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= REG_REGION_LENGTH;
      csr_ch.data         <= '0;
      reset_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_sample_extremes();
      test_zero_frame_count();
      test_zero_frame_size();
      test_spare_register();
      test_single_write_restart();
      test_largest_settings();
      test_output_backpressure();
      test_random_runs();

      settle();
      if (mismatches == 0 && pending_frames.size() == 0) begin
         $display("frame_mean_abs_level: match");
      end else begin
         $display("frame_mean_abs_level: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fmal_pkg.sv
rtl/fmal_ifs.sv
rtl/fmal_div.sv
rtl/fmal_datapath.sv
rtl/fmal_ctrl.sv
rtl/frame_mean_abs_level.sv
tb/sv/tb_frame_mean_abs_level.sv
